@@ sv/ple_pkg.sv @@
`timescale 1ns / 1ps

package ple_pkg;

  // Request kinds as they arrive in the kind field.
  typedef enum logic [3:0] {
    KIND_PUSH_FRONT   = 4'd0,
    KIND_INSERT       = 4'd1,
    KIND_APPEND       = 4'd2,
    KIND_DELETE_AT    = 4'd3,
    KIND_POP_BACK     = 4'd4,
    KIND_DELETE_VALUE = 4'd5,
    KIND_OVERWRITE    = 4'd6,
    KIND_READ         = 4'd7,
    KIND_REVERSE      = 4'd8,
    KIND_COUNT        = 4'd9
  } ple_kind_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_POS   = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } ple_status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_FLUSH,
    ST_PUT,
    ST_DN,
    ST_DN_FLUSH,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_RD,
    ST_RD_WAIT,
    ST_REV_RI,
    ST_REV_RJ,
    ST_REV_WI,
    ST_REV_WJ,
    ST_DONE
  } ple_state_e;

  // Request beat.
  typedef struct packed {
    logic [3:0]         kind;
    logic [5:0]         position;
    logic signed [31:0] value;
  } ple_req_t;

  // Result beat.
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         length_after;
  } ple_rsp_t;

endpackage

@@ sv/ple_ram.sv @@
`timescale 1ns / 1ps

module ple_ram
  import ple_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic signed [31:0]       rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic signed [31:0]       wr_data_i
);

  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/ple_seq.sv @@
`timescale 1ns / 1ps

module ple_seq
  import ple_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  input  ple_req_t                 req_i,
  output logic                     busy_o,
  output logic                     done_valid_o,
  input  logic                     done_take_i,
  output ple_rsp_t                 rsp_o,
  output logic                     rd_en_o,
  output logic [$clog2(DEPTH)-1:0] rd_addr_o,
  input  logic signed [31:0]       rd_data_i,
  output logic                     wr_en_o,
  output logic [$clog2(DEPTH)-1:0] wr_addr_o,
  output logic signed [31:0]       wr_data_o
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (LEN_W > 6) ? LEN_W : 7;

  ple_state_e         state_q, state_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic [ADDR_W-1:0]  jdx_q, jdx_d;
  logic [ADDR_W-1:0]  at_q, at_d;
  logic signed [31:0] val_q, val_d;
  logic signed [31:0] tmp_q, tmp_d;
  logic               pend_q, pend_d;
  logic [ADDR_W-1:0]  pend_addr_q, pend_addr_d;
  logic [2:0]         status_q, status_d;
  logic signed [31:0] rd_q, rd_d;

  logic               full;
  logic               empty;
  logic               pos_ok;
  logic [LEN_W-1:0]   len_m1;
  logic [ADDR_W-1:0]  last_a;
  logic [ADDR_W-1:0]  pos_a;
  logic               rev_more;

  // Request checks against the current length.
  assign full     = (len_q == LEN_W'(DEPTH));
  assign empty    = (len_q == '0);
  assign pos_ok   = (CMP_W'(req_i.position) < CMP_W'(len_q));
  assign len_m1   = len_q - LEN_W'(1);
  assign last_a   = len_m1[ADDR_W-1:0];
  assign pos_a    = ADDR_W'(req_i.position);
  assign rev_more = ((ADDR_W + 1)'(idx_q) + (ADDR_W + 1)'(2)) < (ADDR_W + 1)'(jdx_q);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      pend_q  <= pend_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    jdx_q       <= jdx_d;
    at_q        <= at_d;
    val_q       <= val_d;
    tmp_q       <= tmp_d;
    pend_addr_q <= pend_addr_d;
    status_q    <= status_d;
    rd_q        <= rd_d;
  end

  // Sequencer: shifts move one entry a cycle through the read-modify-write
  // pipe, with the write of an entry following in the cycle after its read.
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    idx_d       = idx_q;
    jdx_d       = jdx_q;
    at_d        = at_q;
    val_d       = val_q;
    tmp_d       = tmp_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    status_d    = status_q;
    rd_d        = rd_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = idx_q;
    wr_en_o     = pend_q;
    wr_addr_o   = pend_addr_q;
    wr_data_o   = rd_data_i;

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          val_d    = req_i.value;
          status_d = STAT_OK;
          rd_d     = '0;
          state_d  = ST_DONE;
          case (req_i.kind)
            KIND_PUSH_FRONT: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                at_d = '0;
                if (empty) begin
                  state_d = ST_PUT;
                end else begin
                  idx_d   = last_a;
                  state_d = ST_UP;
                end
              end
            end
            KIND_INSERT: begin
              priority if (full) begin
                status_d = STAT_FULL;
              end else if (empty) begin
                status_d = STAT_EMPTY;
              end else if (!pos_ok) begin
                status_d = STAT_BAD_POS;
              end else begin
                at_d    = pos_a;
                idx_d   = last_a;
                state_d = ST_UP;
              end
            end
            KIND_APPEND: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                wr_en_o   = 1'b1;
                wr_addr_o = len_q[ADDR_W-1:0];
                wr_data_o = req_i.value;
                len_d     = len_q + LEN_W'(1);
              end
            end
            KIND_DELETE_AT: begin
              priority if (empty) begin
                status_d = STAT_EMPTY;
              end else if (!pos_ok) begin
                status_d = STAT_BAD_POS;
              end else if (pos_a == last_a) begin
                len_d = len_m1;
              end else begin
                idx_d   = pos_a + ADDR_W'(1);
                state_d = ST_DN;
              end
            end
            KIND_POP_BACK: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else begin
                len_d = len_m1;
              end
            end
            KIND_DELETE_VALUE: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = ST_SCAN;
              end
            end
            KIND_OVERWRITE: begin
              priority if (empty) begin
                status_d = STAT_EMPTY;
              end else if (!pos_ok) begin
                status_d = STAT_BAD_POS;
              end else begin
                wr_en_o   = 1'b1;
                wr_addr_o = pos_a;
                wr_data_o = req_i.value;
              end
            end
            KIND_READ: begin
              priority if (empty) begin
                status_d = STAT_EMPTY;
              end else if (!pos_ok) begin
                status_d = STAT_BAD_POS;
              end else begin
                idx_d   = pos_a;
                state_d = ST_RD;
              end
            end
            KIND_REVERSE: begin
              if (len_q > LEN_W'(1)) begin
                idx_d   = '0;
                jdx_d   = last_a;
                state_d = ST_REV_RI;
              end
            end
            default: begin
              // Count and unused kinds change nothing.
            end
          endcase
        end
      end

      // Move entries up by one, from the tail down to the insert point.
      ST_UP: begin
        rd_en_o     = 1'b1;
        pend_d      = 1'b1;
        pend_addr_d = idx_q + ADDR_W'(1);
        if (idx_q == at_q) begin
          state_d = ST_UP_FLUSH;
        end else begin
          idx_d = idx_q - ADDR_W'(1);
        end
      end

      ST_UP_FLUSH: begin
        state_d = ST_PUT;
      end

      ST_PUT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = at_q;
        wr_data_o = val_q;
        len_d     = len_q + LEN_W'(1);
        state_d   = ST_DONE;
      end

      // Move entries down by one, from just past the gap to the tail.
      ST_DN: begin
        rd_en_o     = 1'b1;
        pend_d      = 1'b1;
        pend_addr_d = idx_q - ADDR_W'(1);
        if (idx_q == last_a) begin
          state_d = ST_DN_FLUSH;
        end else begin
          idx_d = idx_q + ADDR_W'(1);
        end
      end

      ST_DN_FLUSH: begin
        len_d   = len_m1;
        state_d = ST_DONE;
      end

      // First-match search: read one entry, then compare it.
      ST_SCAN: begin
        rd_en_o = 1'b1;
        state_d = ST_SCAN_CMP;
      end

      ST_SCAN_CMP: begin
        priority if (rd_data_i == val_q) begin
          if (idx_q == last_a) begin
            len_d   = len_m1;
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + ADDR_W'(1);
            state_d = ST_DN;
          end
        end else if (idx_q == last_a) begin
          status_d = STAT_NOT_FOUND;
          state_d  = ST_DONE;
        end else begin
          idx_d   = idx_q + ADDR_W'(1);
          state_d = ST_SCAN;
        end
      end

      ST_RD: begin
        rd_en_o = 1'b1;
        state_d = ST_RD_WAIT;
      end

      ST_RD_WAIT: begin
        rd_d    = rd_data_i;
        state_d = ST_DONE;
      end

      // Reverse: swap the outer pair, then step both ends inward.
      ST_REV_RI: begin
        rd_en_o = 1'b1;
        state_d = ST_REV_RJ;
      end

      ST_REV_RJ: begin
        rd_en_o   = 1'b1;
        rd_addr_o = jdx_q;
        tmp_d     = rd_data_i;
        state_d   = ST_REV_WI;
      end

      ST_REV_WI: begin
        wr_en_o   = 1'b1;
        wr_addr_o = idx_q;
        wr_data_o = rd_data_i;
        state_d   = ST_REV_WJ;
      end

      ST_REV_WJ: begin
        wr_en_o   = 1'b1;
        wr_addr_o = jdx_q;
        wr_data_o = tmp_q;
        if (rev_more) begin
          idx_d   = idx_q + ADDR_W'(1);
          jdx_d   = jdx_q - ADDR_W'(1);
          state_d = ST_REV_RI;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (done_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign done_valid_o      = (state_q == ST_DONE);
  assign rsp_o.status       = status_q;
  assign rsp_o.read_value   = rd_q;
  assign rsp_o.length_after = 7'(len_q);

endmodule

@@ sv/positional_list_engine.sv @@
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit entries kept in one synchronous
// RAM with one read and one write port; one request at a time, one result
// beat per request. Append, pop back, overwrite, count and any refused
// request touch no more than one entry; push front and insert shift the
// entries from the tail down to the position, delete at a position shifts
// the entries after it, a value delete searches from the front and then
// shifts, and reverse swaps pairs from both ends inward. The single RAM
// read port sets the pace: shifts move one entry per cycle, the search
// reads and then compares one entry at a time and a reverse swap costs two
// reads and two writes. A request is taken as soon as the previous one has
// handed its result to the output register, even while that result is still
// stalled; the last step waits for as long as the output stays full and
// stalled. Entries are not cleared after reset, so the block is ready at once.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ple_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ple_rsp_t out_data_o
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic               busy;
  logic               done_valid;
  logic               done_take;
  ple_rsp_t           rsp;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic signed [31:0] rd_data;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic signed [31:0] wr_data;
  logic               out_valid_q, out_valid_d;
  ple_rsp_t           out_data_q;

  ple_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid_i),
    .req_i        (in_data_i),
    .busy_o       (busy),
    .done_valid_o (done_valid),
    .done_take_i  (done_take),
    .rsp_o        (rsp),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  ple_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign in_stall_o = busy;

  // Output register: loads a finished result when empty or being drained.
  assign done_take = done_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (done_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_take) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An accepted request keeps the sequencer busy in the next cycle.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("request accepted but sequencer not busy");

  // A finished result that cannot move yet stays put.
  a_done_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (done_valid && !done_take) |=> (done_valid && $stable(rsp))
  ) else $error("finished result lost or changed while waiting");

  // A handed-over result shows up on the output beat.
  a_take_loads: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_take |=> (out_valid_o && (out_data_o == $past(rsp)))
  ) else $error("result not loaded into output register");

  // The shift pipeline never reads the entry it is writing.
  a_no_rw_clash: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != wr_addr)
  ) else $error("RAM read and write hit the same entry");

endmodule

@@ dv/tb_positional_list_engine.sv @@
`timescale 1ns / 1ps

module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int DEPTH = 64;

  // Kinds outside the defined set; the block must answer them and change nothing.
  localparam logic [3:0] KIND_JUNK_LO = 4'd10;
  localparam logic [3:0] KIND_JUNK_HI = 4'd15;

  // Cycles the receiver holds off when it deliberately backs the block up.
  localparam int LONG_HOLD = 250;

  // Shadow copy of the list; it computes the result beat each request must produce.
  class list_shadow;
    logic signed [31:0] cells [DEPTH];
    int unsigned        count;
    ple_rsp_t           due_q [$];
    int                 errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      count  = 0;
      errors = 0;
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction

    // Open a hole at the given index and place the value there.
    function void insert_at(int unsigned at, logic signed [31:0] v);
      for (int unsigned i = count; i > at; i--) cells[i] = cells[i - 1];
      cells[at] = v;
      count++;
    endfunction

    // Close the hole left by removing the entry at the given index.
    function void remove_at(int unsigned at);
      for (int unsigned i = at; i + 1 < count; i++) cells[i] = cells[i + 1];
      count--;
    endfunction

    // Apply one accepted request and queue the result beat it must produce.
    function void note_request(ple_req_t r);
      ple_rsp_t           rsp;
      int unsigned        p;
      bit                 full;
      bit                 empty;
      bit                 pos_ok;
      logic signed [31:0] t;
      p      = r.position;
      full   = (count >= DEPTH);
      empty  = (count == 0);
      pos_ok = (p < count);
      rsp.status     = STAT_OK;
      rsp.read_value = '0;
      case (r.kind)
        KIND_PUSH_FRONT: begin
          if (full) rsp.status = STAT_FULL;
          else insert_at(0, r.value);
        end
        KIND_INSERT: begin
          if (full) rsp.status = STAT_FULL;
          else if (empty) rsp.status = STAT_EMPTY;
          else if (!pos_ok) rsp.status = STAT_BAD_POS;
          else insert_at(p, r.value);
        end
        KIND_APPEND: begin
          if (full) rsp.status = STAT_FULL;
          else insert_at(count, r.value);
        end
        KIND_DELETE_AT: begin
          if (empty) rsp.status = STAT_EMPTY;
          else if (!pos_ok) rsp.status = STAT_BAD_POS;
          else remove_at(p);
        end
        KIND_POP_BACK: begin
          if (empty) rsp.status = STAT_EMPTY;
          else count--;
        end
        KIND_DELETE_VALUE: begin
          if (empty) begin
            rsp.status = STAT_EMPTY;
          end else begin
            // Only the first equal entry goes.
            rsp.status = STAT_NOT_FOUND;
            for (int unsigned i = 0; i < count; i++) begin
              if (cells[i] == r.value) begin
                remove_at(i);
                rsp.status = STAT_OK;
                break;
              end
            end
          end
        end
        KIND_OVERWRITE: begin
          if (empty) rsp.status = STAT_EMPTY;
          else if (!pos_ok) rsp.status = STAT_BAD_POS;
          else cells[p] = r.value;
        end
        KIND_READ: begin
          if (empty) rsp.status = STAT_EMPTY;
          else if (!pos_ok) rsp.status = STAT_BAD_POS;
          else rsp.read_value = cells[p];
        end
        KIND_REVERSE: begin
          for (int unsigned i = 0; i < count / 2; i++) begin
            t                    = cells[i];
            cells[i]             = cells[count - 1 - i];
            cells[count - 1 - i] = t;
          end
        end
        KIND_COUNT: begin
        end
        default: begin
        end
      endcase
      rsp.length_after = 7'(count);
      due_q.push_back(rsp);
    endfunction

    // Compare one accepted result beat with the oldest pending one.
    function void check_result(ple_rsp_t got);
      ple_rsp_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unrequested result beat, expected none, got status %0d value %0d length %0d",
                 $time, got.status, got.read_value, got.length_after);
        return;
      end
      want = due_q.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, got %0d",
                 $time, want.status, got.status);
      end
      if (got.read_value !== want.read_value) begin
        errors++;
        $display("%0t: read_value mismatch, expected %0d, got %0d",
                 $time, want.read_value, got.read_value);
      end
      if (got.length_after !== want.length_after) begin
        errors++;
        $display("%0t: length_after mismatch, expected %0d, got %0d",
                 $time, want.length_after, got.length_after);
      end
    endfunction
  endclass

  // Direction the random requests push the list length.
  typedef enum int {
    TREND_GROW,
    TREND_SHRINK,
    TREND_MIXED
  } trend_e;

  // Kind weights per trend, indexed by kind code 0 to 15.
  int unsigned kind_wt [3][16] = '{
    '{20, 22, 20, 4, 3, 4, 6, 6, 3, 2, 1, 1, 1, 1, 1, 1},
    '{4, 4, 4, 22, 18, 22, 6, 6, 3, 2, 1, 1, 1, 1, 1, 1},
    '{8, 8, 8, 8, 8, 8, 10, 10, 6, 4, 1, 1, 1, 1, 1, 1}
  };

  logic     clk_i;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  ple_req_t in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ple_rsp_t out_data;

  list_shadow shadow = new();

  trend_e trend      = TREND_GROW;
  int     rail_hits  = 0;
  int     mixed_left = 0;
  int     snd_left   = 0;
  bit     snd_calm   = 1'b0;
  int     rcv_left   = 0;
  bit     rcv_calm   = 1'b0;

  positional_list_engine #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Idle cycles before the next beat: stretches of busy traffic alternate with
  // stretches of random gaps.
  function automatic int draw_wait(inout int left, inout bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      left = $urandom_range(10, 50);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic ple_req_t make_req(logic [3:0] k, logic [5:0] p, logic signed [31:0] v);
    ple_req_t r;
    r.kind     = k;
    r.position = p;
    r.value    = v;
    return r;
  endfunction

  // Random request; the trend walks the list from empty to full and back.
  function automatic ple_req_t pick_req();
    ple_req_t    r;
    int unsigned total;
    int unsigned roll;
    int unsigned acc;
    int          v;
    case (trend)
      TREND_GROW: begin
        if (shadow.count == DEPTH) rail_hits++;
        if (rail_hits > 4) begin
          trend     = TREND_SHRINK;
          rail_hits = 0;
        end
      end
      TREND_SHRINK: begin
        if (shadow.count == 0) rail_hits++;
        if (rail_hits > 4) begin
          trend      = TREND_MIXED;
          rail_hits  = 0;
          mixed_left = $urandom_range(40, 120);
        end
      end
      default: begin
        if (mixed_left == 0) trend = TREND_GROW;
        else mixed_left--;
      end
    endcase

    total = 0;
    for (int k = 0; k < 16; k++) total += kind_wt[trend][k];
    roll = $urandom_range(0, total - 1);
    acc  = 0;
    r    = '0;
    for (int k = 0; k < 16; k++) begin
      acc += kind_wt[trend][k];
      if (roll < acc) begin
        r.kind = 4'(k);
        break;
      end
    end

    // Mostly valid positions with the ends favored, some anywhere in range.
    if (shadow.count > 0 && $urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 3))
        0: r.position = '0;
        1: r.position = 6'(shadow.count - 1);
        default: r.position = 6'($urandom_range(0, shadow.count - 1));
      endcase
    end else begin
      r.position = 6'($urandom_range(0, 63));
    end

    // Value deletes usually name a value that is present.
    if (r.kind == KIND_DELETE_VALUE && shadow.count > 0 && $urandom_range(0, 3) != 0) begin
      r.value = shadow.cells[$urandom_range(0, shadow.count - 1)];
    end else begin
      case ($urandom_range(0, 3))
        0, 1: r.value = $urandom;
        2: begin
          // Small pool so that duplicates occur.
          v       = $urandom_range(0, 6);
          r.value = v - 3;
        end
        default: r.value = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      endcase
    end
    return r;
  endfunction

  // Offer one request beat and hold it until the block takes it.
  task automatic offer_req(input ple_req_t r);
    int gap;
    gap = draw_wait(snd_left, snd_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk_i); while (in_stall);
    shadow.note_request(r);
  endtask

  // Stop offering until every pending result beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (shadow.outstanding() != 0);
  endtask

  // Result side: random stalls, and two long hold-offs that back the block up.
  initial begin
    int hold;
    int seen;
    seen = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (seen == 300 || seen == 1000) hold = LONG_HOLD;
      else hold = draw_wait(rcv_left, rcv_calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
      shadow.check_result(out_data);
      seen++;
    end
  end

  // Hard limit on the whole run.
  initial begin
    #20_000_000;
    $display("tb_positional_list_engine: done, errors");
    $finish;
  end

  initial begin
    ple_req_t drill [$];
    ple_req_t r;
    int       real_items;
    bit       paused;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Refusals on an empty list, then the extremes, then back to empty.
    drill.push_back(make_req(KIND_READ, 6'd0, 32'sd0));
    drill.push_back(make_req(KIND_DELETE_AT, 6'd0, 32'sd0));
    drill.push_back(make_req(KIND_POP_BACK, 6'd0, 32'sd0));
    drill.push_back(make_req(KIND_DELETE_VALUE, 6'd0, 32'sd0));
    drill.push_back(make_req(KIND_OVERWRITE, 6'd0, 32'sd5));
    drill.push_back(make_req(KIND_INSERT, 6'd0, 32'sd7));
    drill.push_back(make_req(KIND_REVERSE, 6'd0, 32'sd0));
    drill.push_back(make_req(KIND_COUNT, 6'd0, 32'sd0));
    drill.push_back(make_req(KIND_JUNK_HI, 6'd63, -32'sd1));
    drill.push_back(make_req(KIND_PUSH_FRONT, 6'd63, 32'sh7fffffff));
    drill.push_back(make_req(KIND_APPEND, 6'd0, 32'sh80000000));
    drill.push_back(make_req(KIND_REVERSE, 6'd0, 32'sd0));
    drill.push_back(make_req(KIND_INSERT, 6'd1, -32'sd1));
    drill.push_back(make_req(KIND_INSERT, 6'd63, 32'sd9));
    drill.push_back(make_req(KIND_READ, 6'd2, 32'sd0));
    drill.push_back(make_req(KIND_READ, 6'd0, 32'sd0));
    drill.push_back(make_req(KIND_OVERWRITE, 6'd1, 32'sd0));
    drill.push_back(make_req(KIND_READ, 6'd63, 32'sd0));
    drill.push_back(make_req(KIND_DELETE_VALUE, 6'd0, 32'sd12345));
    drill.push_back(make_req(KIND_DELETE_VALUE, 6'd0, 32'sd0));
    drill.push_back(make_req(KIND_DELETE_AT, 6'd5, 32'sd0));
    drill.push_back(make_req(KIND_DELETE_AT, 6'd0, 32'sd0));
    drill.push_back(make_req(KIND_POP_BACK, 6'd0, 32'sd0));
    drill.push_back(make_req(KIND_COUNT, 6'd0, 32'sd0));
    drill.push_back(make_req(KIND_JUNK_LO, 6'd0, 32'sd0));
    foreach (drill[i]) offer_req(drill[i]);
    drain();

    // Random traffic; ignored kinds count toward the total like any other.
    real_items = 0;
    paused     = 1'b0;
    while (real_items < 1525) begin
      r = pick_req();
      offer_req(r);
      real_items++;
      if (!paused && real_items == 750) begin
        paused = 1'b1;
        drain();
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.outstanding() == 0) begin
      $display("tb_positional_list_engine: done, clean");
    end else begin
      $display("tb_positional_list_engine: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ple_pkg.sv
sv/ple_ram.sv
sv/ple_seq.sv
sv/positional_list_engine.sv
dv/tb_positional_list_engine.sv
